@@ rtl/core/bhpq_pkg.sv @@
// Shared types, codes and helpers of the binary heap priority queue core.
package bhpq_pkg;

	localparam int DEPTH = 1024;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = AW + 1;
	localparam int KW    = 32;

	typedef logic [AW-1:0]        addr_t;
	typedef logic [CW-1:0]        count_t;
	typedef logic signed [KW-1:0] key_t;
	typedef logic [3:0]           cmd_t;

	localparam key_t KEY_MAX = {1'b0, {(KW-1){1'b1}}};
	localparam key_t KEY_MIN = {1'b1, {(KW-1){1'b0}}};

	localparam logic [1:0] FUNC_INSERT  = 2'd0;
	localparam logic [1:0] FUNC_EXTRACT = 2'd1;
	localparam logic [1:0] FUNC_CHANGE  = 2'd2;
	localparam logic [1:0] FUNC_DELETE  = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_EMPTY   = 2'd2;
	localparam logic [1:0] ST_BAD_POS = 2'd3;

	localparam cmd_t CMD_NONE   = 4'd0;
	localparam cmd_t CMD_LOAD   = 4'd1;
	localparam cmd_t CMD_INS    = 4'd2;
	localparam cmd_t CMD_FULL   = 4'd3;
	localparam cmd_t CMD_EMPTY  = 4'd4;
	localparam cmd_t CMD_BADPOS = 4'd5;
	localparam cmd_t CMD_EXT    = 4'd6;
	localparam cmd_t CMD_TAKE   = 4'd7;
	localparam cmd_t CMD_LDCUR  = 4'd8;
	localparam cmd_t CMD_CHG    = 4'd9;
	localparam cmd_t CMD_DEL    = 4'd10;
	localparam cmd_t CMD_UP_RD  = 4'd11;
	localparam cmd_t CMD_UP_MV  = 4'd12;
	localparam cmd_t CMD_PUT    = 4'd13;
	localparam cmd_t CMD_DN_RL  = 4'd14;
	localparam cmd_t CMD_DN_RR  = 4'd15;

	typedef struct packed {
		logic [1:0] func;
		logic       full;
		logic       empty;
		logic       bad_pos;
		logic       k_zero;
		logic       up_move;
		logic       lc_ok;
		logic       dn_move;
		logic       out_busy;
	} dp_status_t;

	typedef struct packed {
		cmd_t cmd;
		logic dn_mv;
		logic done;
	} dp_cmd_t;

	function automatic logic ranks_above(key_t a, key_t b, logic mode);
		return mode ? (a > b) : (a < b);
	endfunction

endpackage

@@ rtl/core/binary_heap_priority_queue_core.sv @@
// Top level of the binary heap priority queue core.
// Usage:
// The slave stream takes one request word: tuser carries the request kind
// (insert, extract top, change key, delete at position), tdata the key and
// the array position. The master stream returns one result word per request:
// extracted key, status, root key, root valid flag and entry count.
// The cfg channel writes the order mode (0 min-heap, 1 max-heap); write it
// only while no request is in flight and preferably while the heap is empty.
// A request is worked on alone; the key store is one memory with one read and
// one write port, so each level going up is a parent read and then a compare
// and move, and each level going down is a left child read, a right child read
// and a compare and move. Change key sifts up as insert does and, if it did not
// move up, sifts down as extract does; delete does both in turn.
// The result sits in an output register: the next request is taken while it
// waits, and a finished request holds in the controller until the receiver
// takes the previous word.
// Reset empties the heap and selects min mode; the memory is not cleared,
// since only entries below the count are ever used.
module binary_heap_priority_queue_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // key_value[31:0], position[41:32], zero pad
	input  logic [1:0]  s_axis_tuser,  // func[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata,  // result_value[31:0], status[33:32], top_value[65:34],
	                                   // top_valid[66], entry_count[77:67], zero pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data
);
	import bhpq_pkg::*;

	dp_status_t stat;
	dp_cmd_t    cmd;
	key_t       out_result;
	logic [1:0] out_status;
	key_t       out_top;
	logic       out_top_valid;
	count_t     out_count;

	bhpq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bhpq_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_data      (cfg_data),
		.in_func       (s_axis_tuser),
		.in_key        (s_axis_tdata[31:0]),
		.in_pos        (s_axis_tdata[41:32]),
		.cmd           (cmd),
		.stat          (stat),
		.out_ready     (m_axis_tready),
		.out_valid     (m_axis_tvalid),
		.out_result    (out_result),
		.out_status    (out_status),
		.out_top       (out_top),
		.out_top_valid (out_top_valid),
		.out_count     (out_count)
	);

	assign cfg_ready    = 1'b1;
	assign m_axis_tdata = {2'b00, out_count, out_top_valid, out_top, out_status, out_result};

endmodule

@@ rtl/core/bhpq_dp.sv @@
// Datapath of the heap core: key store, sift registers, count, mode and result word.
module bhpq_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic                cfg_data,
	input  logic [1:0]          in_func,
	input  bhpq_pkg::key_t      in_key,
	input  bhpq_pkg::addr_t     in_pos,
	input  bhpq_pkg::dp_cmd_t   cmd,
	output bhpq_pkg::dp_status_t stat,
	input  logic                out_ready,
	output logic                out_valid,
	output bhpq_pkg::key_t      out_result,
	output logic [1:0]          out_status,
	output bhpq_pkg::key_t      out_top,
	output logic                out_top_valid,
	output bhpq_pkg::count_t    out_count
);
	import bhpq_pkg::*;

	key_t   mem [DEPTH];
	key_t   rdata_q;
	logic   we;
	logic   re;
	addr_t  waddr;
	addr_t  raddr;
	key_t   wdata;

	logic [1:0] func_q;
	key_t       key_q;
	addr_t      pos_q;
	count_t     cnt_q;
	logic       mode_q;
	addr_t      k_q;
	key_t       cur_q;
	key_t       root_q;
	key_t       best_key_q;
	logic       lc_win_q;
	logic       rc_ok_q;
	key_t       res_q;
	logic [1:0] st_q;
	logic       out_valid_q;
	key_t       out_res_q;
	logic [1:0] out_st_q;
	key_t       out_top_q;
	logic       out_tv_q;
	count_t     out_cnt_q;

	count_t        cnt_dec;
	addr_t         k_dec;
	addr_t         parent;
	logic [AW+1:0] lc;
	logic [AW+1:0] rc;
	logic          lc_wins;
	logic          rc_wins;
	key_t          fin_key;
	addr_t         fin_idx;
	key_t          sentinel;

	assign cnt_dec  = cnt_q - count_t'(1);
	assign k_dec    = k_q - addr_t'(1);
	assign parent   = k_dec >> 1;
	assign lc       = {1'b0, k_q, 1'b1};
	assign rc       = {1'b0, k_q, 1'b0} + (AW+2)'(2);
	assign lc_wins  = ranks_above(rdata_q, cur_q, mode_q);
	assign rc_wins  = rc_ok_q && ranks_above(rdata_q, best_key_q, mode_q);
	assign fin_key  = rc_wins ? rdata_q : best_key_q;
	assign fin_idx  = rc_wins ? rc[AW-1:0] : (lc_win_q ? lc[AW-1:0] : k_q);
	assign sentinel = mode_q ? KEY_MIN : KEY_MAX;

	assign stat.func     = func_q;
	assign stat.full     = (cnt_q == count_t'(DEPTH));
	assign stat.empty    = (cnt_q == '0);
	assign stat.bad_pos  = ({1'b0, pos_q} >= cnt_q);
	assign stat.k_zero   = (k_q == '0);
	assign stat.up_move  = ranks_above(cur_q, rdata_q, mode_q);
	assign stat.lc_ok    = (lc < {1'b0, cnt_q});
	assign stat.dn_move  = rc_wins || lc_win_q;
	assign stat.out_busy = out_valid_q && !out_ready;

	always_comb begin
		we    = 1'b0;
		re    = 1'b0;
		waddr = k_q;
		raddr = k_q;
		wdata = cur_q;
		if (cmd.dn_mv) begin
			we    = 1'b1;
			wdata = fin_key;
		end
		case (cmd.cmd)
			CMD_UP_RD: begin
				re    = 1'b1;
				raddr = parent;
			end
			CMD_UP_MV: begin
				we    = 1'b1;
				wdata = rdata_q;
			end
			CMD_PUT: begin
				we = 1'b1;
			end
			CMD_EXT, CMD_TAKE: begin
				re    = 1'b1;
				raddr = cnt_dec[AW-1:0];
			end
			CMD_DN_RL: begin
				re    = 1'b1;
				raddr = lc[AW-1:0];
			end
			CMD_DN_RR: begin
				re    = 1'b1;
				raddr = rc[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (we && waddr == '0) begin
			root_q <= wdata;
		end
		if (cmd.dn_mv) begin
			k_q <= fin_idx;
		end
		case (cmd.cmd)
			CMD_LOAD: begin
				func_q <= in_func;
				key_q  <= in_key;
				pos_q  <= in_pos;
			end
			CMD_INS: begin
				k_q   <= cnt_q[AW-1:0];
				cur_q <= key_q;
				res_q <= '0;
				st_q  <= ST_OK;
			end
			CMD_FULL: begin
				res_q <= '0;
				st_q  <= ST_FULL;
			end
			CMD_EMPTY: begin
				res_q <= sentinel;
				st_q  <= ST_EMPTY;
			end
			CMD_BADPOS: begin
				res_q <= '0;
				st_q  <= ST_BAD_POS;
			end
			CMD_EXT: begin
				res_q <= root_q;
				st_q  <= ST_OK;
				k_q   <= '0;
			end
			CMD_TAKE: begin
				k_q <= '0;
			end
			CMD_LDCUR: begin
				cur_q <= rdata_q;
			end
			CMD_CHG: begin
				k_q   <= pos_q;
				cur_q <= key_q;
				res_q <= '0;
				st_q  <= ST_OK;
			end
			CMD_DEL: begin
				k_q   <= pos_q;
				cur_q <= mode_q ? KEY_MAX : KEY_MIN;
				res_q <= '0;
				st_q  <= ST_OK;
			end
			CMD_UP_MV: begin
				k_q <= parent;
			end
			CMD_DN_RR: begin
				lc_win_q   <= lc_wins;
				best_key_q <= lc_wins ? rdata_q : cur_q;
				rc_ok_q    <= (rc < {1'b0, cnt_q});
			end
			default: begin
			end
		endcase
		if (cmd.done) begin
			out_res_q <= res_q;
			out_st_q  <= st_q;
			out_top_q <= (cnt_q != '0) ? root_q : sentinel;
			out_tv_q  <= (cnt_q != '0);
			out_cnt_q <= cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			mode_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				mode_q <= cfg_data;
			end
			if (cmd.cmd == CMD_INS) begin
				cnt_q <= cnt_q + count_t'(1);
			end else if (cmd.cmd == CMD_EXT || cmd.cmd == CMD_TAKE) begin
				cnt_q <= cnt_dec;
			end
			if (cmd.done) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign out_result    = out_res_q;
	assign out_status    = out_st_q;
	assign out_top       = out_top_q;
	assign out_top_valid = out_tv_q;
	assign out_count     = out_cnt_q;

endmodule

@@ rtl/core/bhpq_ctrl.sv @@
// Controller state machine of the heap core: decodes a request and sequences the sifts.
module bhpq_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  bhpq_pkg::dp_status_t stat,
	output bhpq_pkg::dp_cmd_t    cmd
);
	import bhpq_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DECODE = 4'd1;
	localparam logic [3:0] S_UP_RD  = 4'd2;
	localparam logic [3:0] S_UP_CMP = 4'd3;
	localparam logic [3:0] S_TAKE   = 4'd4;
	localparam logic [3:0] S_TAKE_W = 4'd5;
	localparam logic [3:0] S_DN_L   = 4'd6;
	localparam logic [3:0] S_DN_R   = 4'd7;
	localparam logic [3:0] S_DN_C   = 4'd8;
	localparam logic [3:0] S_DONE   = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       first_q;
	logic       first_d;
	logic [3:0] up_next;

	always_comb begin
		if (stat.func == FUNC_CHANGE && first_q) begin
			up_next = S_DN_L;
		end else if (stat.func == FUNC_DELETE) begin
			up_next = S_TAKE;
		end else begin
			up_next = S_DONE;
		end
	end

	always_comb begin
		state_d   = state_q;
		first_d   = first_q;
		cmd.cmd   = CMD_NONE;
		cmd.dn_mv = 1'b0;
		cmd.done  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.cmd = CMD_LOAD;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				first_d = 1'b1;
				case (stat.func)
					FUNC_INSERT: begin
						cmd.cmd = stat.full ? CMD_FULL : CMD_INS;
						state_d = stat.full ? S_DONE : S_UP_RD;
					end
					FUNC_EXTRACT: begin
						cmd.cmd = stat.empty ? CMD_EMPTY : CMD_EXT;
						state_d = stat.empty ? S_DONE : S_TAKE_W;
					end
					FUNC_CHANGE: begin
						cmd.cmd = stat.bad_pos ? CMD_BADPOS : CMD_CHG;
						state_d = stat.bad_pos ? S_DONE : S_UP_RD;
					end
					default: begin
						cmd.cmd = stat.bad_pos ? CMD_BADPOS : CMD_DEL;
						state_d = stat.bad_pos ? S_DONE : S_UP_RD;
					end
				endcase
			end
			S_UP_RD: begin
				if (stat.k_zero) begin
					cmd.cmd = CMD_PUT;
					state_d = up_next;
				end else begin
					cmd.cmd = CMD_UP_RD;
					state_d = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				if (stat.up_move) begin
					cmd.cmd = CMD_UP_MV;
					first_d = 1'b0;
					state_d = S_UP_RD;
				end else begin
					cmd.cmd = CMD_PUT;
					state_d = up_next;
				end
			end
			S_TAKE: begin
				cmd.cmd = CMD_TAKE;
				state_d = S_TAKE_W;
			end
			S_TAKE_W: begin
				cmd.cmd = CMD_LDCUR;
				state_d = S_DN_L;
			end
			S_DN_L: begin
				if (stat.lc_ok) begin
					cmd.cmd = CMD_DN_RL;
					state_d = S_DN_R;
				end else begin
					cmd.cmd = CMD_PUT;
					state_d = S_DONE;
				end
			end
			S_DN_R: begin
				cmd.cmd = CMD_DN_RR;
				state_d = S_DN_C;
			end
			S_DN_C: begin
				if (stat.dn_move) begin
					cmd.dn_mv = 1'b1;
					state_d   = S_DN_L;
				end else begin
					cmd.cmd = CMD_PUT;
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!stat.out_busy) begin
					cmd.done = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			first_q <= 1'b0;
		end else begin
			state_q <= state_d;
			first_q <= first_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

endmodule
